// File: sv/int8_group_scaled_gemv_unit_assert.svh
// Assertion macros for the int8 group-scaled GEMV unit.
// Included by RTL files that check their own control logic; no other dependencies.
`ifndef INT8_GROUP_SCALED_GEMV_UNIT_ASSERT_SVH
`define INT8_GROUP_SCALED_GEMV_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent.
`define GSG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GSG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define GSG_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define GSG_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: sv/gsg_pkg.sv
// Shared types and constants for the int8 group-scaled GEMV unit.
// No dependencies; imported by int8_group_scaled_gemv_unit.
`default_nettype none

package gsg_pkg;

   // Activation store depth and row counter wrap.
   localparam int MAX_K    = 4096;
   localparam int MAX_ROWS = 4096;
   localparam int COL_W    = $clog2(MAX_K);
   localparam int ROW_W    = $clog2(MAX_ROWS);

   // Configuration register layout.
   localparam int CFG_W    = 13;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;
   localparam logic [CFG_W-1:0] ROW_LENGTH_RESET = 13'd896;
   localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 13'd64;
   localparam logic REG_ROW_LENGTH = 1'b0;
   localparam logic REG_GROUP_SIZE = 1'b1;

   // Command codes.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_WEIGHT = 1'b1;

   // Datapath widths.
   localparam int ACT_W    = 16;
   localparam int WGT_W    = 8;
   localparam int SCALE_W  = 16;
   localparam int PROD_W   = ACT_W + WGT_W;
   localparam int SCALED_W = 40;
   localparam int ACC_W    = 64;
   localparam int OUT_W    = 32;
   localparam int FRAC_DROP = 16;

   typedef struct packed {
      logic                     cmd;
      logic [11:0]              act_index;
      logic signed [ACT_W-1:0]  act_value;
      logic signed [WGT_W-1:0]  weight;
      logic [SCALE_W-1:0]       group_scale;
   } req_payload_type;

   typedef struct packed {
      logic [11:0]              row_index;
      logic signed [OUT_W-1:0]  row_value;
      logic                     saturated;
   } rsp_payload_type;

endpackage

`default_nettype wire

// File: sv/int8_group_scaled_gemv_unit.sv
// Int8 group-scaled GEMV unit: a single module with the activation store,
// multiply pipeline, accumulator and APB register file. Depends on gsg_pkg.
//
// The unit takes one beat per cycle while req_ready is high. Load beats write the
// activation store; weight beats read it at the current column, then flow through
// a read stage, a weight-times-activation multiply, a times-scale multiply and the
// 64-bit accumulate. The weight beat that ends a row blocks req_ready until its
// result beat is taken: the row total passes the stage 1 to 3 registers, the final
// sum register and the response register before that beat is valid, and any stall
// on rsp_ready holds the row further. The single-port activation store sets the
// one-beat-per-cycle rate. There is no clearing pass after reset.
`default_nettype none

module int8_group_scaled_gemv_unit
   import gsg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [ADDR_W-1:0]     csr_paddr,
   input  wire logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]          csr_prdata,
   output logic                       csr_pready
);

`include "int8_group_scaled_gemv_unit_assert.svh"

   // Configuration registers.
   logic [CFG_W-1:0] row_length_ff, group_size_ff;
   logic             csr_write;

   // Row control state.
   logic [COL_W-1:0]   col_cnt_ff;
   logic [CFG_W-1:0]   grp_pos_ff;
   logic [SCALE_W-1:0] cur_scale_ff;
   logic [ROW_W-1:0]   row_cnt_ff;
   logic               row_pend_ff;

   // Activation store.
   logic [ACT_W-1:0] act_mem [MAX_K];
   logic [ACT_W-1:0] mem_rd_ff;

   // Pipeline.
   logic                     s1_valid_ff, s1_last_ff;
   logic signed [WGT_W-1:0]  s1_weight_ff;
   logic [SCALE_W-1:0]       s1_scale_ff;
   logic                     s2_valid_ff, s2_last_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SCALE_W-1:0]       s2_scale_ff;
   logic                     s3_valid_ff, s3_last_ff;
   logic signed [SCALED_W-1:0] scaled_ff;
   logic signed [ACC_W-1:0]  acc_ff, fin_sum_ff;
   logic                     fin_valid_ff;
   logic                     rsp_valid_ff;
   rsp_payload_type          rsp_ff;

   // Stage 0 decode.
   logic [CFG_W-1:0]   k_eff, gs_eff, col_next;
   logic               req_fire, wt_fire, ld_fire, rsp_fire;
   logic               new_group, row_last;
   logic [SCALE_W-1:0] scale_sel;

   // Accumulate and finalize.
   logic signed [ACC_W-1:0]   acc_sum, rounded;
   logic signed [ACC_W-FRAC_DROP-1:0] shifted;
   logic [ACC_W-FRAC_DROP-OUT_W:0]    top_bits;
   logic                      sat_hi, sat_lo;
   logic signed [OUT_W-1:0]   out_value;

   // ---------------------------------------------------------------- CSR
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         group_size_ff <= GROUP_SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_ROW_LENGTH: row_length_ff <= csr_pwdata[CFG_W-1:0];
            REG_GROUP_SIZE: group_size_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_ROW_LENGTH: csr_prdata = DATA_W'(row_length_ff);
         REG_GROUP_SIZE: csr_prdata = DATA_W'(group_size_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- stage 0
   always_comb begin
      if (row_length_ff == '0)
         k_eff = CFG_W'(1);
      else if (row_length_ff > CFG_W'(MAX_K))
         k_eff = CFG_W'(MAX_K);
      else
         k_eff = row_length_ff;
      gs_eff = (group_size_ff == '0) ? CFG_W'(1) : group_size_ff;
   end

   assign req_ready = ~row_pend_ff;
   assign req_fire  = req_valid & req_ready;
   assign wt_fire   = req_fire & (req_payload.cmd == CMD_WEIGHT);
   assign ld_fire   = req_fire & (req_payload.cmd == CMD_LOAD);
   assign rsp_fire  = rsp_valid_ff & rsp_ready;

   assign new_group = (grp_pos_ff == '0) || (grp_pos_ff >= gs_eff);
   assign scale_sel = new_group ? req_payload.group_scale : cur_scale_ff;
   assign col_next  = CFG_W'(col_cnt_ff) + CFG_W'(1);
   assign row_last  = col_next >= k_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff   <= '0;
         grp_pos_ff   <= '0;
         cur_scale_ff <= '0;
         row_pend_ff  <= 1'b0;
      end else begin
         if (wt_fire) begin
            cur_scale_ff <= scale_sel;
            if (row_last) begin
               col_cnt_ff  <= '0;
               grp_pos_ff  <= '0;
               row_pend_ff <= 1'b1;
            end else begin
               col_cnt_ff <= col_next[COL_W-1:0];
               grp_pos_ff <= new_group ? CFG_W'(1) : grp_pos_ff + CFG_W'(1);
            end
         end
         if (rsp_fire)
            row_pend_ff <= 1'b0;
      end
   end

   // The store sees one access per cycle: a load writes, a weight reads.
   always_ff @(posedge clock) begin
      if (ld_fire)
         act_mem[req_payload.act_index[COL_W-1:0]] <= req_payload.act_value;
      if (wt_fire)
         mem_rd_ff <= act_mem[col_cnt_ff];
   end

   // ---------------------------------------------------------------- stages 1-3
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= wt_fire;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff   <= row_last;
      s1_weight_ff <= req_payload.weight;
      s1_scale_ff  <= scale_sel;
      s2_last_ff   <= s1_last_ff;
      s2_scale_ff  <= s1_scale_ff;
      prod_ff      <= PROD_W'(s1_weight_ff * $signed(mem_rd_ff));
      s3_last_ff   <= s2_last_ff;
      // Magnitude stays below 2^38, so 40 bits hold the product exactly.
      scaled_ff    <= SCALED_W'(prod_ff * $signed({1'b0, s2_scale_ff}));
   end

   // ---------------------------------------------------------------- accumulate
   assign acc_sum = acc_ff + ACC_W'(scaled_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= s3_valid_ff & s3_last_ff;
         if (s3_valid_ff)
            acc_ff <= s3_last_ff ? '0 : acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff & s3_last_ff)
         fin_sum_ff <= acc_sum;
   end

   // ---------------------------------------------------------------- round, clip
   assign rounded  = fin_sum_ff + ACC_W'(32768);
   assign shifted  = rounded[ACC_W-1:FRAC_DROP];
   assign top_bits = shifted[ACC_W-FRAC_DROP-1:OUT_W-1];
   assign sat_hi   = ~top_bits[ACC_W-FRAC_DROP-OUT_W] & (|top_bits);
   assign sat_lo   = top_bits[ACC_W-FRAC_DROP-OUT_W] & ~(&top_bits);

   always_comb begin
      if (sat_hi)
         out_value = {1'b0, {(OUT_W-1){1'b1}}};
      else if (sat_lo)
         out_value = {1'b1, {(OUT_W-1){1'b0}}};
      else
         out_value = shifted[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         row_cnt_ff   <= '0;
      end else begin
         if (fin_valid_ff) begin
            rsp_valid_ff <= 1'b1;
            row_cnt_ff   <= (row_cnt_ff == ROW_W'(MAX_ROWS - 1)) ? '0
                                                                  : row_cnt_ff + ROW_W'(1);
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid_ff) begin
         rsp_ff.row_index <= 12'(row_cnt_ff);
         rsp_ff.row_value <= out_value;
         rsp_ff.saturated <= sat_hi | sat_lo;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------- checks
   // A result beat only exists while its row holds off further input.
   `GSG_ASSERT_SAME(a_rsp_needs_pend, clock, reset, rsp_valid_ff, row_pend_ff)
   // When the row total lands, nothing behind it is still in the pipeline.
   `GSG_ASSERT_SAME(a_fin_drained, clock, reset, fin_valid_ff,
                    !s1_valid_ff && !s2_valid_ff && !s3_valid_ff)
   // A clipped result carries one of the two 32-bit extremes.
   `GSG_ASSERT_SAME(a_sat_extreme, clock, reset, rsp_valid_ff && rsp_ff.saturated,
                    rsp_ff.row_value == {1'b0, {(OUT_W-1){1'b1}}} ||
                    rsp_ff.row_value == {1'b1, {(OUT_W-1){1'b0}}})
   // The beat that ends a row rewinds the column and group counters.
   `GSG_ASSERT_NEXT(a_row_rewind, clock, reset, wt_fire && row_last,
                    col_cnt_ff == '0 && grp_pos_ff == '0)

endmodule

`default_nettype wire
